[rtl/cscd_pkg.sv]
`default_nettype none

package cscd_pkg;

   localparam int TRACK_BITS   = 16;
   localparam int MAX_REQUESTS = 32;
   localparam int STORE_DEPTH  = MAX_REQUESTS + 3;
   localparam int CNT_BITS     = $clog2(STORE_DEPTH + 1);
   localparam int PTR_BITS     = $clog2(STORE_DEPTH);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAD_POSITION  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_TRACK      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIRECTION_DOWN = 2'd2;

   localparam logic [TRACK_BITS-1:0] HEAD_POSITION_RESET = '0;
   localparam logic [TRACK_BITS-1:0] END_TRACK_RESET     = '1;

   typedef struct packed {
      logic [TRACK_BITS-1:0] track;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [TRACK_BITS-1:0] track_res;
      logic                  last_res;
   } rsp_type;

   typedef struct packed {
      logic [TRACK_BITS-1:0] head_position;
      logic [TRACK_BITS-1:0] end_track;
      logic                  direction_down;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      req_type word;
   } qlink_type;

   typedef struct packed {
      logic                emitting;
      logic [CNT_BITS-1:0] count;
   } bk_stat_type;

endpackage

`default_nettype wire

[rtl/cscd_front.sv]
`default_nettype none

module cscd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire cscd_pkg::req_type   req_data,
   output logic                     busy,
   output cscd_pkg::qlink_type      q_link,
   input  wire logic                q_pop
);
   import cscd_pkg::*;

   req_type                word_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [QCNT_BITS-1:0]   fill_ff, fill_in;
   logic                   push;
   logic                   pop;

   assign busy         = (fill_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign push         = start && !busy;
   assign pop          = q_pop && (fill_ff != '0);
   assign q_link.valid = (fill_ff != '0);
   assign q_link.word  = word_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         word_ff[wr_ff] <= req_data;
      end
   end

endmodule

`default_nettype wire

[rtl/cscd_back.sv]
`default_nettype none

module cscd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cscd_pkg::qlink_type q_link,
   output logic                     q_pop,
   input  wire cscd_pkg::cfg_type   cfg,
   output logic                     rsp_strobe,
   output cscd_pkg::rsp_type        rsp_data,
   output cscd_pkg::bk_stat_type    stat
);
   import cscd_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_END  = 7'b0000010,
      ST_ZERO = 7'b0000100,
      ST_SCAN = 7'b0001000,
      ST_HEAD = 7'b0010000,
      ST_SEEK = 7'b0100000,
      ST_EMIT = 7'b1000000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [TRACK_BITS-1:0]   cell_ff [STORE_DEPTH];
   logic [TRACK_BITS-1:0]   cell_in [STORE_DEPTH];
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     emit_ff, emit_in;
   logic [PTR_BITS-1:0]     slot_ff, slot_in;
   logic [PTR_BITS-1:0]     slot_up, slot_dn;
   logic                    found_ff, found_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    ins_en;
   logic [TRACK_BITS-1:0]   ins_val;
   logic                    rot_left, rot_right;
   logic [STORE_DEPTH-1:0]  gt;
   logic [STORE_DEPTH-1:0]  gt_prev;
   logic                    valid0, valid1, hit0, hit1;
   logic                    stop_seek, emit_last;

   assign slot_up   = (slot_ff == PTR_BITS'(STORE_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign slot_dn   = (slot_ff == '0) ? PTR_BITS'(STORE_DEPTH - 1) : slot_ff - 1'b1;
   assign valid0    = CNT_BITS'(slot_ff) < count_ff;
   assign valid1    = CNT_BITS'(slot_up) < count_ff;
   assign hit0      = valid0 && (cell_ff[0] == cfg.head_position);
   assign hit1      = valid1 && (cell_ff[1] == cfg.head_position);
   assign stop_seek = hit0 && ((slot_ff == PTR_BITS'(STORE_DEPTH - 1)) || !hit1);
   assign emit_last = valid0 && ((emit_ff + 1'b1) == count_ff);
   assign gt_prev   = {gt[STORE_DEPTH-2:0], 1'b0};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      emit_in       = emit_ff;
      slot_in       = slot_ff;
      found_in      = found_ff;
      ins_en        = 1'b0;
      ins_val       = '0;
      rot_left      = 1'b0;
      rot_right     = 1'b0;
      q_pop         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in.track_res = cell_ff[0];
      rsp_in.last_res  = emit_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_link.valid) begin
               q_pop = 1'b1;
               if (count_ff < CNT_BITS'(MAX_REQUESTS)) begin
                  ins_en  = 1'b1;
                  ins_val = q_link.word.track;
               end
               if (q_link.word.last) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            ins_en   = 1'b1;
            ins_val  = cfg.end_track;
            state_in = ST_ZERO;
         end
         ST_ZERO: begin
            ins_en   = 1'b1;
            ins_val  = '0;
            slot_in  = '0;
            found_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rot_left = 1'b1;
            slot_in  = slot_up;
            found_in = found_ff || hit0;
            if (slot_ff == PTR_BITS'(STORE_DEPTH - 1)) begin
               state_in = (found_ff || hit0) ? ST_SEEK : ST_HEAD;
            end
         end
         ST_HEAD: begin
            ins_en   = 1'b1;
            ins_val  = cfg.head_position;
            state_in = ST_SEEK;
         end
         ST_SEEK: begin
            if (stop_seek) begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end else begin
               rot_left = 1'b1;
               slot_in  = slot_up;
            end
         end
         ST_EMIT: begin
            if (cfg.direction_down) begin
               rot_right = 1'b1;
               slot_in   = slot_dn;
            end else begin
               rot_left = 1'b1;
               slot_in  = slot_up;
            end
            if (valid0) begin
               rsp_strobe_in = 1'b1;
               emit_in       = emit_ff + 1'b1;
               if (emit_last) begin
                  count_in = '0;
                  slot_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (ins_en && (count_ff < CNT_BITS'(STORE_DEPTH))) begin
         count_in = count_ff + 1'b1;
      end
   end

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      localparam int NEXT = (i + 1) % STORE_DEPTH;
      localparam int PREV = (i + STORE_DEPTH - 1) % STORE_DEPTH;

      assign gt[i] = (CNT_BITS'(i) < count_ff) && (cell_ff[i] > ins_val);

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (ins_en) begin
            if (gt[i] || (CNT_BITS'(i) == count_ff)) begin
               cell_in[i] = gt_prev[i] ? cell_ff[PREV] : ins_val;
            end
         end else if (rot_left) begin
            cell_in[i] = cell_ff[NEXT];
         end else if (rot_right) begin
            cell_in[i] = cell_ff[PREV];
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         emit_ff       <= '0;
         slot_ff       <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         emit_ff       <= emit_in;
         slot_ff       <= slot_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_data      = rsp_ff;
   assign stat.emitting = (state_ff == ST_EMIT);
   assign stat.count    = count_ff;

endmodule

`default_nettype wire

[rtl/cscd_disk_request_order_top_placeholder.sv]
`default_nettype none

module cscd_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   input  wire logic [cscd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [cscd_pkg::TRACK_BITS-1:0]       csr_data,
   output cscd_pkg::cfg_type                          cfg
);
   import cscd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HEAD_POSITION:  cfg_in.head_position  = csr_data;
            CSR_END_TRACK:      cfg_in.end_track      = csr_data;
            CSR_DIRECTION_DOWN: cfg_in.direction_down = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_position  <= HEAD_POSITION_RESET;
         cfg_ff.end_track      <= END_TRACK_RESET;
         cfg_ff.direction_down <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/cscan_disk_request_order.sv]
// C-SCAN request ordering. Requests are sent on req_data with start while busy is low; a
// two-word queue decouples intake from the sorter, which inserts one request per cycle into
// an ascending row of 35 cells while no closed batch is being sorted or sent (requests past
// 32 in a batch are dropped). The word with last set closes the batch: end track and track 0
// are inserted, a full rotation of the cell row checks for the head track, the head is
// inserted if missing, the row is rotated to the last entry equal to the head, and then its n
// entries come out on rsp_data, one per cycle while the order needs no wrap; a wrap passes
// the 35 - n empty cells in either direction. rsp_strobe marks each word for exactly one
// cycle and the receiver cannot stall it; last_res flags the final word. Requests of the
// next batch queue up during output and busy rises when the queue is full. csr_ready is
// always high; write configuration only while no batch closed by last is still being
// sorted or sent.
`default_nettype none

module cscan_disk_request_order (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire cscd_pkg::req_type                     req_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cscd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [cscd_pkg::TRACK_BITS-1:0]       csr_data,
   output logic                                       rsp_strobe,
   output cscd_pkg::rsp_type                          rsp_data
);
   import cscd_pkg::*;

   cfg_type     cfg;
   qlink_type   q_link;
   logic        q_pop;
   bk_stat_type bk_stat;

   assign csr_ready = 1'b1;

   cscd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cscd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .q_link   (q_link),
      .q_pop    (q_pop)
   );

   cscd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_link     (q_link),
      .q_pop      (q_pop),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .stat       (bk_stat)
   );

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_res |=> !rsp_strobe)
      else $error("word strobed right after the final word");

   a_emit_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_res |-> bk_stat.emitting)
      else $error("output ended before the final word");

   a_count: assert property (@(posedge clock) disable iff (reset)
      bk_stat.count <= CNT_BITS'(STORE_DEPTH))
      else $error("entry count beyond store depth");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("strobe or busy after reset");

endmodule

`default_nettype wire

[tb/cscan_disk_request_order_tb.sv]
`timescale 1ns / 100ps

module cscan_disk_request_order_tb;
   import cscd_pkg::*;

   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 195;
   localparam int MAX_REPORTS    = 40;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef logic [TRACK_BITS-1:0] track_list_type [$];

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   req_type                   req_data  = '0;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [TRACK_BITS-1:0]     csr_data  = '0;
   logic                      rsp_strobe;
   rsp_type                   rsp_data;

   logic [TRACK_BITS-1:0] track_row [STORE_DEPTH];
   int                    row_count    = 0;
   cfg_type               shadow_cfg   = '{HEAD_POSITION_RESET, END_TRACK_RESET, 1'b0};
   rsp_type               service_q [$];
   int                    errors       = 0;
   int                    quiet_cycles = 0;
   int                    items_sent   = 0;
   bit                    idle_on      = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cscan_disk_request_order i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   function automatic void insert_track(logic [TRACK_BITS-1:0] value);
      int pos;
      if (row_count >= STORE_DEPTH) return;
      pos = row_count;
      while (pos > 0 && track_row[pos-1] > value) begin
         track_row[pos] = track_row[pos-1];
         pos--;
      end
      track_row[pos] = value;
      row_count++;
   endfunction

   function automatic void cscan_order(req_type w);
      int      seq [$];
      int      pick;
      bit      found;
      rsp_type word_out;
      if (row_count < MAX_REQUESTS) insert_track(w.track);
      if (!w.last) return;
      insert_track(shadow_cfg.end_track);
      insert_track('0);
      found = 1'b0;
      for (int i = 0; i < row_count; i++)
         if (track_row[i] == shadow_cfg.head_position) found = 1'b1;
      if (!found) insert_track(shadow_cfg.head_position);
      pick = 0;
      for (int i = 0; i < row_count; i++)
         if (track_row[i] == shadow_cfg.head_position) pick = i;
      if (!shadow_cfg.direction_down) begin
         for (int i = pick; i < row_count; i++) seq.push_back(i);
         for (int i = 0; i < pick; i++) seq.push_back(i);
      end else begin
         for (int i = pick; i >= 0; i--) seq.push_back(i);
         for (int i = row_count - 1; i > pick; i--) seq.push_back(i);
      end
      foreach (seq[k]) begin
         word_out.track_res = track_row[seq[k]];
         word_out.last_res  = (k == seq.size() - 1);
         service_q.push_back(word_out);
      end
      row_count = 0;
   endfunction

   function automatic logic [TRACK_BITS-1:0] pick_track();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 15));
         1: return shadow_cfg.head_position;
         2: return shadow_cfg.end_track;
         3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [TRACK_BITS-1:0] pick_config_value();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_word(logic [TRACK_BITS-1:0] track, bit last);
      req_type w;
      w.track = track;
      w.last  = last;
      start    <= 1'b1;
      req_data <= w;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      cscan_order(w);
      items_sent++;
   endtask

   task automatic rest_sender(int cycles);
      start          <= 1'b0;
      req_data.track <= 16'($urandom);
      req_data.last  <= 1'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic pace();
      if (idle_on && $urandom_range(0, 2) == 0) rest_sender($urandom_range(1, 8));
   endtask

   task automatic send_batch(track_list_type tracks);
      foreach (tracks[k]) begin
         send_word(tracks[k], k == tracks.size() - 1);
         pace();
      end
   endtask

   // hold off until every word is out and the block has settled
   task automatic wait_drained();
      start <= 1'b0;
      while (service_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [TRACK_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      case (index)
         CSR_HEAD_POSITION:  shadow_cfg.head_position  = data;
         CSR_END_TRACK:      shadow_cfg.end_track      = data;
         CSR_DIRECTION_DOWN: shadow_cfg.direction_down = data[0];
         default: ;
      endcase
   endtask

   task automatic config_block(logic [TRACK_BITS-1:0] head, logic [TRACK_BITS-1:0] end_trk,
                               logic [TRACK_BITS-1:0] dir_word);
      wait_drained();
      write_reg(CSR_HEAD_POSITION, head);
      write_reg(CSR_END_TRACK, end_trk);
      write_reg(CSR_DIRECTION_DOWN, dir_word);
      csr_valid <= 1'b0;
   endtask

   task automatic test_defaults();
      send_batch({16'hFFFF});
      send_batch({16'h0000});
   endtask

   task automatic test_extremes();
      config_block(16'hFFFF, 16'h0000, 16'h0001);
      send_batch({16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF});
      config_block(16'h0000, 16'hFFFF, 16'h0000);
      send_batch({16'hAAAA, 16'h5555});
   endtask

   task automatic test_head_match();
      config_block(16'd100, 16'd500, 16'h0000);
      send_batch({16'd100, 16'd50, 16'd100, 16'd600});
      config_block(16'd100, 16'd500, 16'h0001);
      send_batch({16'd100, 16'd50, 16'd100, 16'd600});
      config_block(16'd300, 16'd1000, 16'hFFFF);
      send_batch({16'd20, 16'd400, 16'd999});
      config_block(16'd300, 16'd1000, 16'hFFFE);
      send_batch({16'd20, 16'd400, 16'd999});
   endtask

   task automatic test_duplicates();
      config_block(16'd7, 16'd7, 16'h0000);
      send_batch({16'd7, 16'd7, 16'd0});
      config_block(16'd7, 16'd7, 16'h0001);
      send_batch({16'd0, 16'd7});
   endtask

   task automatic test_unknown_index();
      wait_drained();
      write_reg(CSR_UNUSED, 16'hFFFF);
      write_reg(CSR_UNUSED, 16'h0000);
      csr_valid <= 1'b0;
      send_batch({16'h0123, 16'hFEDC});
   endtask

   // overflow: requests past the capacity are dropped, the batch still closes
   task automatic test_full_batch();
      config_block(pick_config_value(), pick_config_value(), 16'($urandom));
      for (int j = 0; j < MAX_REQUESTS + 4; j++) begin
         send_word(pick_track(), j == MAX_REQUESTS + 3);
         pace();
      end
   endtask

   task automatic test_random_batches();
      int len;
      int target;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (items_sent > target - RANDOM_ITEMS / 5) idle_on = 1'b0;
         if (idle_on) begin
            case ($urandom_range(0, 7))
               0, 1: config_block(pick_config_value(), pick_config_value(), 16'($urandom));
               2: wait_drained();
               default: ;
            endcase
         end
         len = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 38) : $urandom_range(1, 9);
         for (int j = 0; j < len; j++) begin
            send_word(pick_track(), j == len - 1);
            pace();
         end
      end
   endtask

   always @(negedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (service_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: word with nothing expected: track_res=%h last_res=%b",
                        $time, rsp_data.track_res, rsp_data.last_res);
         end else begin
            want = service_q.pop_front();
            if (rsp_data.track_res !== want.track_res) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: track_res expected %h actual %h",
                           $time, want.track_res, rsp_data.track_res);
            end
            if (rsp_data.last_res !== want.last_res) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: last_res expected %b actual %b",
                           $time, want.last_res, rsp_data.last_res);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1 || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d words outstanding",
                  $time, quiet_cycles, service_q.size());
         $display("cscan_disk_request_order_tb failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_extremes();
      test_head_match();
      test_duplicates();
      test_unknown_index();
      test_full_batch();
      test_random_batches();
      wait_drained();
      if (errors == 0) begin
         $display("cscan_disk_request_order_tb passed");
      end else begin
         $display("cscan_disk_request_order_tb failed");
      end
      $finish;
   end

endmodule
